[hw/rtl/cfe_pkg.sv]
// shared constants, codes and queue entry type for the cuckoo filter engine
package cfe_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] MIX_MULT  = 32'h045d9f3b;
  localparam logic [31:0] LFSR_TAPS = 32'h80200003;

  localparam int BUCKET_CNT_W = 11;
  localparam int CFG_DATA_W   = 32;
  localparam logic [BUCKET_CNT_W-1:0] BUCKETS_RESET = 11'd1024;
  localparam logic [CFG_DATA_W-1:0]   SEED_RESET    = 32'd1;

  localparam int DEF_BUCKET_TOTAL  = 1024;
  localparam int DEF_SLOTS         = 4;
  localparam int DEF_MAX_EVICTIONS = 500;

  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_CONTAINS = 2'd1,
    OP_REMOVE   = 2'd2
  } op_t;

  typedef enum logic {
    CFG_BUCKETS = 1'b0,
    CFG_SEED    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] hash;
    logic [1:0]  op;
  } q_entry_t;

endpackage

[hw/rtl/cfe_front.sv]
// key byte intake: fnv-1a hashing and hand-off of finished keys
module cfe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_operation,
  input  logic [7:0]        in_key_byte,
  input  logic              in_last_byte,
  input  logic              hold,
  input  logic              q_full,
  output logic              q_push,
  output cfe_pkg::q_entry_t q_data
);

  logic [31:0] hash_r;
  logic [31:0] hash_nxt;
  logic [31:0] mixed;
  logic        accept;

  assign in_full = q_full | hold;
  assign accept  = in_push & ~in_full;
  assign mixed   = (hash_r ^ {24'd0, in_key_byte}) * cfe_pkg::FNV_PRIME;

  assign q_push       = accept & in_last_byte;
  assign q_data.hash  = mixed;
  assign q_data.op    = in_operation;

  always_comb begin
    hash_nxt = hash_r;
    if (accept) begin
      hash_nxt = in_last_byte ? cfe_pkg::FNV_BASIS : mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= cfe_pkg::FNV_BASIS;
    end else begin
      hash_r <= hash_nxt;
    end
  end

endmodule

[hw/rtl/cfe_fifo.sv]
// short queue of finished keys between intake and table engine
module cfe_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cfe_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output cfe_pkg::q_entry_t head,
  output logic              valid
);

  localparam int PW = (cfe_pkg::Q_DEPTH > 1) ? $clog2(cfe_pkg::Q_DEPTH) : 1;
  localparam int CW = $clog2(cfe_pkg::Q_DEPTH + 1);

  cfe_pkg::q_entry_t store_r [cfe_pkg::Q_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          do_push, do_pop;

  assign full    = (fill_r == CW'(cfe_pkg::Q_DEPTH));
  assign valid   = (fill_r != '0);
  assign head    = store_r[rd_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  always_comb begin
    wr_nxt   = wr_r;
    rd_nxt   = rd_r;
    fill_nxt = fill_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(cfe_pkg::Q_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(cfe_pkg::Q_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

[hw/rtl/cfe_divu.sv]
// bit-serial remainder unit: 32-bit dividend, narrow divisor, one bit a cycle
module cfe_divu (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [31:0]                      dividend,
  input  logic [cfe_pkg::BUCKET_CNT_W-1:0] divisor,
  output logic                             busy,
  output logic                             done,
  output logic [cfe_pkg::BUCKET_CNT_W-1:0] rem
);

  localparam int DW = cfe_pkg::BUCKET_CNT_W;

  logic [31:0]   dvd_r;
  logic [DW-1:0] div_r;
  logic [DW-1:0] rem_r;
  logic [4:0]    step_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_r, dvd_r[31]};
  assign ge    = (trial >= {1'b0, div_r});
  assign busy  = busy_r;
  assign done  = done_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        dvd_r  <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r  <= ge ? DW'(trial - {1'b0, div_r}) : DW'(trial);
        dvd_r  <= {dvd_r[30:0], 1'b0};
        step_r <= step_r + 1'b1;
        if (step_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/cfe_back.sv]
// table engine: bucket indexing, fingerprint table, insert/lookup/remove sequencer
module cfe_back #(
  parameter int BUCKET_TOTAL     = cfe_pkg::DEF_BUCKET_TOTAL,
  parameter int SLOTS_PER_BUCKET = cfe_pkg::DEF_SLOTS,
  parameter int MAX_EVICTIONS    = cfe_pkg::DEF_MAX_EVICTIONS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  cfe_pkg::q_entry_t              q_head,
  output logic                           q_pop,
  output logic                           clearing,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [cfe_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_success,
  output logic [12:0]                    out_item_count
);

  localparam int DW    = cfe_pkg::BUCKET_CNT_W;
  localparam int TABLE = BUCKET_TOTAL * SLOTS_PER_BUCKET;
  localparam int BW    = $clog2(BUCKET_TOTAL);
  localparam int AW    = $clog2(TABLE);
  localparam int SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int SL    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 0;
  localparam int NW    = $clog2(MAX_EVICTIONS + 1);
  localparam int CW    = $clog2(TABLE + 1);

  // rounded-up reciprocal of the slot count, exact quotient for any 32-bit value
  localparam logic [32:0] SLOT_RECIP =
    33'(((64'd1 << (32 + SL)) / 64'(SLOTS_PER_BUCKET)) + 64'd1);

  typedef logic [31:0] mix_tab_t [256];

  function automatic mix_tab_t build_mix();
    mix_tab_t    t;
    logic [31:0] v;
    for (int i = 0; i < 256; i++) begin
      v = 32'(i);
      v = ((v >> 16) ^ v) * cfe_pkg::MIX_MULT;
      v = ((v >> 16) ^ v) * cfe_pkg::MIX_MULT;
      t[i] = (v >> 16) ^ v;
    end
    return t;
  endfunction

  localparam mix_tab_t MIX_TAB = build_mix();

  // hash mod 255 by folding bytes, then plus one
  function automatic logic [7:0] fp_of(input logic [31:0] h);
    logic [9:0] s;
    logic [8:0] s2;
    logic [7:0] s3;
    s  = 10'(h[7:0]) + 10'(h[15:8]) + 10'(h[23:16]) + 10'(h[31:24]);
    s2 = 9'(s[9:8]) + 9'(s[7:0]);
    s3 = 8'(s2[8]) + s2[7:0];
    return (s3 == 8'd255) ? 8'd1 : s3 + 8'd1;
  endfunction

  function automatic logic [31:0] lfsr_step(input logic [31:0] l);
    return (l >> 1) ^ (l[0] ? cfe_pkg::LFSR_TAPS : 32'd0);
  endfunction

  // lfsr mod slot count through the reciprocal
  function automatic logic [SW-1:0] slot_of(input logic [31:0] l);
    logic [64:0] prod;
    logic [31:0] quo;
    logic [31:0] rest;
    prod = 65'(l) * 65'(SLOT_RECIP);
    quo  = 32'(prod >> (32 + SL));
    rest = l - quo * 32'(SLOTS_PER_BUCKET);
    return SW'(rest);
  endfunction

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_B1, S_B2,
    S_PE_RD, S_PE_CHK,
    S_KICK_START, S_KICK_MOD, S_KICK_RD, S_KICK_CHK, S_KICK_ALT,
    S_LK_RDP, S_LK_CHKP, S_LK_RDQ, S_LK_CHKQ,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {PH_PRIMARY, PH_ALTERNATE, PH_EVICT} phase_t;

  state_t        state_r, state_nxt;
  phase_t        phase_r, phase_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [31:0]   h_r, h_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [7:0]    fp_r, fp_nxt;
  logic [BW-1:0] b1_r, b1_nxt, b2_r, b2_nxt, cur_r, cur_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [NW-1:0] kicks_r, kicks_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ok_r, ok_nxt;
  logic          res_v_r, res_v_nxt;
  logic          res_ok_r, res_ok_nxt;
  logic [12:0]   res_cnt_r, res_cnt_nxt;
  logic [DW-1:0] buckets_r, buckets_nxt;
  logic [31:0]   lfsr_r, lfsr_nxt;
  logic [31:0]   lfsr_adv;

  logic [7:0]    mem_r [TABLE];
  logic [7:0]    rdata_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr, slot_addr;
  logic [7:0]    mem_wd;

  logic          mod_start, mod_busy, mod_done;
  logic [31:0]   mod_dvd;
  logic [DW-1:0] mod_div, mod_rem, eff_b;
  logic          res_taken;

  cfe_divu u_divu (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (mod_div),
    .busy     (mod_busy),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    if (buckets_r == '0) begin
      eff_b = DW'(1);
    end else if (32'(buckets_r) > 32'(BUCKET_TOTAL)) begin
      eff_b = DW'(BUCKET_TOTAL);
    end else begin
      eff_b = buckets_r;
    end
  end

  assign slot_addr      = AW'(cur_r) * AW'(SLOTS_PER_BUCKET) + AW'(slot_r);
  assign lfsr_adv       = lfsr_step(lfsr_r);
  assign clearing       = (state_r == S_CLEAR);
  assign out_empty      = ~res_v_r;
  assign out_success    = res_ok_r;
  assign out_item_count = res_cnt_r;
  assign res_taken      = out_pop & res_v_r;

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    clr_nxt     = clr_r;
    h_nxt       = h_r;
    op_nxt      = op_r;
    fp_nxt      = fp_r;
    b1_nxt      = b1_r;
    b2_nxt      = b2_r;
    cur_nxt     = cur_r;
    slot_nxt    = slot_r;
    kicks_nxt   = kicks_r;
    cnt_nxt     = cnt_r;
    ok_nxt      = ok_r;
    res_v_nxt   = res_v_r & ~res_taken;
    res_ok_nxt  = res_ok_r;
    res_cnt_nxt = res_cnt_r;
    buckets_nxt = buckets_r;
    lfsr_nxt    = lfsr_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = slot_addr;
    mem_wd      = fp_r;
    mod_start   = 1'b0;
    mod_dvd     = h_r;
    mod_div     = eff_b;
    q_pop       = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        mem_wd   = 8'd0;
        if (clr_r == AW'(TABLE - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          h_nxt  = q_head.hash;
          op_nxt = q_head.op;
          fp_nxt = fp_of(q_head.hash);
          case (q_head.op) inside
            cfe_pkg::OP_INSERT, cfe_pkg::OP_CONTAINS, cfe_pkg::OP_REMOVE: begin
              mod_start = 1'b1;
              mod_dvd   = q_head.hash;
              state_nxt = S_B1;
            end
            default: begin
              ok_nxt    = 1'b0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_B1: begin
        if (mod_done) begin
          b1_nxt    = BW'(mod_rem);
          mod_start = 1'b1;
          mod_dvd   = 32'(BW'(mod_rem)) ^ MIX_TAB[fp_r];
          state_nxt = S_B2;
        end
      end
      S_B2: begin
        if (mod_done) begin
          b2_nxt   = BW'(mod_rem);
          cur_nxt  = b1_r;
          slot_nxt = '0;
          if (op_r == cfe_pkg::OP_INSERT) begin
            phase_nxt = PH_PRIMARY;
            state_nxt = S_PE_RD;
          end else begin
            state_nxt = S_LK_RDP;
          end
        end
      end
      S_PE_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_PE_CHK;
      end
      S_PE_CHK: begin
        if (rdata_r == 8'd0) begin
          mem_we    = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end else if (slot_r == SW'(SLOTS_PER_BUCKET - 1)) begin
          slot_nxt = '0;
          unique case (phase_r)
            PH_PRIMARY: begin
              cur_nxt   = b2_r;
              phase_nxt = PH_ALTERNATE;
              state_nxt = S_PE_RD;
            end
            PH_ALTERNATE: begin
              // one lfsr step picks the bucket where evictions start
              lfsr_nxt  = lfsr_adv;
              cur_nxt   = lfsr_adv[0] ? b2_r : b1_r;
              kicks_nxt = '0;
              state_nxt = S_KICK_START;
            end
            PH_EVICT: begin
              if (kicks_r == NW'(MAX_EVICTIONS)) begin
                ok_nxt    = 1'b0;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_KICK_START;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end else begin
          slot_nxt  = slot_r + 1'b1;
          state_nxt = S_PE_RD;
        end
      end
      S_KICK_START: begin
        lfsr_nxt  = lfsr_adv;
        state_nxt = S_KICK_MOD;
      end
      S_KICK_MOD: begin
        slot_nxt  = slot_of(lfsr_r);
        state_nxt = S_KICK_RD;
      end
      S_KICK_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_KICK_CHK;
      end
      S_KICK_CHK: begin
        // swap carried fingerprint in, follow the evicted one
        mem_we    = 1'b1;
        fp_nxt    = rdata_r;
        mod_start = 1'b1;
        mod_dvd   = 32'(cur_r) ^ MIX_TAB[rdata_r];
        state_nxt = S_KICK_ALT;
      end
      S_KICK_ALT: begin
        if (mod_done) begin
          cur_nxt   = BW'(mod_rem);
          kicks_nxt = kicks_r + 1'b1;
          slot_nxt  = '0;
          phase_nxt = PH_EVICT;
          state_nxt = S_PE_RD;
        end
      end
      S_LK_RDP, S_LK_RDQ: begin
        mem_re    = 1'b1;
        state_nxt = (state_r == S_LK_RDP) ? S_LK_CHKP : S_LK_CHKQ;
      end
      S_LK_CHKP, S_LK_CHKQ: begin
        if (rdata_r == fp_r) begin
          if (op_r == cfe_pkg::OP_REMOVE) begin
            mem_we = 1'b1;
            mem_wd = 8'd0;
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end else if (state_r == S_LK_CHKP) begin
          cur_nxt   = b2_r;
          state_nxt = S_LK_RDQ;
        end else if (slot_r == SW'(SLOTS_PER_BUCKET - 1)) begin
          ok_nxt    = 1'b0;
          state_nxt = S_DONE;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          cur_nxt   = b1_r;
          state_nxt = S_LK_RDP;
        end
      end
      S_DONE: begin
        if (!res_v_r || out_pop) begin
          res_v_nxt   = 1'b1;
          res_ok_nxt  = ok_r;
          res_cnt_nxt = 13'(cnt_r);
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        cfe_pkg::CFG_BUCKETS: buckets_nxt = DW'(cfg_data);
        cfe_pkg::CFG_SEED:    lfsr_nxt = (cfg_data == '0) ? 32'd1 : cfg_data;
        default:              buckets_nxt = buckets_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem_r[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      cnt_r     <= '0;
      res_v_r   <= 1'b0;
      buckets_r <= cfe_pkg::BUCKETS_RESET;
      lfsr_r    <= cfe_pkg::SEED_RESET;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      cnt_r     <= cnt_nxt;
      res_v_r   <= res_v_nxt;
      buckets_r <= buckets_nxt;
      lfsr_r    <= lfsr_nxt;
    end
    phase_r   <= phase_nxt;
    h_r       <= h_nxt;
    op_r      <= op_nxt;
    fp_r      <= fp_nxt;
    b1_r      <= b1_nxt;
    b2_r      <= b2_nxt;
    cur_r     <= cur_nxt;
    slot_r    <= slot_nxt;
    kicks_r   <= kicks_nxt;
    ok_r      <= ok_nxt;
    res_ok_r  <= res_ok_nxt;
    res_cnt_r <= res_cnt_nxt;
  end

`ifndef SYNTH
  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !res_v_r)
    else $error("result beat pending during table clear");

  a_divider_idle_between_items: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mod_busy)
    else $error("remainder unit busy with no item in flight");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE))
    else $error("stored count exceeds table size");

  a_queue_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE) && q_valid)
    else $error("key taken from queue while engine busy");
`endif

endmodule

[hw/rtl/cuckoo_filter_engine.sv]
// cuckoo filter engine: key byte intake, key queue and table engine
// flow: a key's last byte queues the key; the table engine computes two bucket remainders,
// then probes slots, each eviction adding a remainder and probes; unknown operations fail
// throughput: one byte per cycle while the key queue has room and no table clear runs;
// the table engine, bound by the bit-serial remainder unit and the single table port,
// takes one key at a time
// reset: in_full is held high while the table clears
module cuckoo_filter_engine #(
  parameter int BUCKET_TOTAL     = cfe_pkg::DEF_BUCKET_TOTAL,
  parameter int SLOTS_PER_BUCKET = cfe_pkg::DEF_SLOTS,
  parameter int MAX_EVICTIONS    = cfe_pkg::DEF_MAX_EVICTIONS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [1:0]                     in_operation,
  input  logic [7:0]                     in_key_byte,
  input  logic                           in_last_byte,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_success,
  output logic [12:0]                    out_item_count,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [cfe_pkg::CFG_DATA_W-1:0] cfg_data
);

  cfe_pkg::q_entry_t q_in, q_head;
  logic              q_push, q_full, q_pop, q_valid, clearing;

  cfe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_operation (in_operation),
    .in_key_byte  (in_key_byte),
    .in_last_byte (in_last_byte),
    .hold         (clearing),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  cfe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .valid     (q_valid)
  );

  cfe_back #(
    .BUCKET_TOTAL     (BUCKET_TOTAL),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
    .MAX_EVICTIONS    (MAX_EVICTIONS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_success    (out_success),
    .out_item_count (out_item_count)
  );

endmodule
